// ===== rtl/rppg_pkg.sv =====
// Shared types, constants and microcode ROM for the plug pairing generator.
// No dependencies; imported by rppg_moddiv and random_plug_pairing_generator.
`timescale 1ns / 1ps

package rppg_pkg;

    localparam int RAND_W   = 15;
    localparam int LETTER_W = 5;
    localparam int PAIR_W   = 4;
    localparam int BITCNT_W = $clog2(RAND_W);
    localparam int PC_W     = 3;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [PAIR_W-1:0] PAIR_TARGET_RST = PAIR_W'(13);

    // command opcodes carried in tuser
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_PAIR    = 1'b1;

    // micro-operations driving the datapath
    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_DIV_STEP,
        UOP_SCAN_STEP,
        UOP_SWAP,
        UOP_EMIT,
        UOP_RESTART,
        UOP_REFUSE
    } uop_t;

    // sequencing conditions
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_DISPATCH,
        COND_LOOP_DIV,
        COND_LOOP_SCAN,
        COND_EMIT
    } cond_t;

    typedef struct packed {
        uop_t              uop;
        cond_t             cond;
        logic [PC_W-1:0]   target;
    } uword_t;

    typedef struct packed {
        logic load;
        logic shift;
    } div_ctl_t;

    // program addresses
    localparam logic [PC_W-1:0] PC_WAIT    = PC_W'(0);
    localparam logic [PC_W-1:0] PC_DIV     = PC_W'(1);
    localparam logic [PC_W-1:0] PC_SCAN    = PC_W'(2);
    localparam logic [PC_W-1:0] PC_SWAP    = PC_W'(3);
    localparam logic [PC_W-1:0] PC_EMIT    = PC_W'(4);
    localparam logic [PC_W-1:0] PC_RESTART = PC_W'(5);
    localparam logic [PC_W-1:0] PC_REFUSE  = PC_W'(6);

    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            PC_WAIT:    w = '{uop: UOP_WAIT,      cond: COND_DISPATCH,  target: PC_WAIT};
            PC_DIV:     w = '{uop: UOP_DIV_STEP,  cond: COND_LOOP_DIV,  target: PC_DIV};
            PC_SCAN:    w = '{uop: UOP_SCAN_STEP, cond: COND_LOOP_SCAN, target: PC_SCAN};
            PC_SWAP:    w = '{uop: UOP_SWAP,      cond: COND_NEXT,      target: PC_EMIT};
            PC_EMIT:    w = '{uop: UOP_EMIT,      cond: COND_EMIT,      target: PC_WAIT};
            PC_RESTART: w = '{uop: UOP_RESTART,   cond: COND_JUMP,      target: PC_EMIT};
            PC_REFUSE:  w = '{uop: UOP_REFUSE,    cond: COND_JUMP,      target: PC_EMIT};
            default:    w = '{uop: UOP_WAIT,      cond: COND_JUMP,      target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/random_plug_pairing_generator.sv =====
// Top level of the plug pairing generator: microcoded sequencer and datapath.
// Depends on rppg_pkg and rppg_moddiv.
`timescale 1ns / 1ps

// Usage
//   s_axis: one command word. tuser[0] = opcode (0 restart, 1 make a pair);
//           tdata = rand_first[14:0], rand_second[29:15], zero pad.
//   m_axis: one result word per command. tdata = letter_first[4:0],
//           letter_second[9:5], pairs_count[13:10], run_done[14],
//           refused[15], board_valid[16], zero pad.
//   cfg:    pair_target write (cfg_data[3:0]), always ready; write only
//           while no command is in flight.
// Sequence
//   A pairing word runs the two bit-serial remainder units side by side,
//   one dividend bit per step, then the free-letter scan, one letter per
//   step, then swap and result load. Restart words clear the board and
//   refused words set the refused flag, then both go to the result load. The result is valid the cycle after load.
// Reset / stall
//   Reset empties the board (all letters free), zeroes the pair count and
//   sets pair_target to 13. While m_axis is stalled the result register
//   holds; the next command is still accepted and its result waits in the
//   sequencer until the output register is free.
module random_plug_pairing_generator
    import rppg_pkg::*;
#(
    parameter int LETTERS = 26
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [PAIR_W-1:0]       cfg_data,       // pair_target
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,   // rand_first, rand_second
    input  logic [0:0]              s_axis_tuser,   // opcode
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata    // first, second, count, done,
                                                    // refused, board_valid
);

    localparam int IW         = $clog2(LETTERS);
    localparam int CW         = $clog2(LETTERS + 1);
    localparam int PAIR_LIMIT = (LETTERS / 2 < 15) ? LETTERS / 2 : 15;
    localparam bit BOARD_OK   = (LETTERS % 2 == 0) && (LETTERS / 2 <= 15);
    localparam int OUT_PAD    = OUT_DATA_W - 2 * LETTER_W - PAIR_W - 3;

    // sequencer
    logic [PC_W-1:0]    pc_reg;
    logic [PC_W-1:0]    pc_next;
    uword_t             uw;

    // board state: only the free/paired flag per letter feeds any result,
    // partners are recorded by the reported pair
    logic [LETTERS-1:0] paired_reg;
    logic [LETTERS-1:0] paired_next;
    logic [PAIR_W-1:0]  pairs_made_reg;
    logic [PAIR_W-1:0]  pairs_made_next;
    logic [PAIR_W-1:0]  pair_target_reg;
    logic [PAIR_W-1:0]  pair_target_next;

    // per-word working registers
    logic [BITCNT_W-1:0] bit_cnt_reg;
    logic [BITCNT_W-1:0] bit_cnt_next;
    logic [IW-1:0]      j_reg;
    logic [IW-1:0]      j_next;
    logic [CW-1:0]      rank_reg;
    logic [CW-1:0]      rank_next;
    logic [IW-1:0]      first_reg;
    logic [IW-1:0]      first_next;
    logic [IW-1:0]      second_reg;
    logic [IW-1:0]      second_next;
    logic               refused_reg;
    logic               refused_next;

    // output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_DATA_W-1:0]  out_data_next;

    logic               in_fire;
    logic               out_free;
    logic               refuse_now;
    logic               div_last;
    logic               scan_last;
    logic [CW-1:0]      unpaired;
    logic [CW-1:0]      c1;
    logic [CW-1:0]      c2;
    logic [CW-1:0]      other;
    logic               run_done;
    logic               board_valid;
    div_ctl_t           div_ctl;

    assign uw = ucode_rom(pc_reg);

    assign cfg_ready = 1'b1;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign refuse_now = (pairs_made_reg >= pair_target_reg)
                     || (pairs_made_reg >= PAIR_W'(PAIR_LIMIT));
    assign div_last   = (bit_cnt_reg == BITCNT_W'(RAND_W - 1));
    assign scan_last  = (j_reg == IW'(LETTERS - 1));

    // free letters left; stable while the remainder units run
    assign unpaired = CW'(LETTERS) - CW'({pairs_made_reg, 1'b0});

    // rank among the free letters once the first pick is skipped
    assign other = (rank_reg < c1) ? rank_reg : rank_reg - CW'(1);

    assign run_done    = (pairs_made_reg == pair_target_reg);
    assign board_valid = BOARD_OK && (pairs_made_reg == PAIR_W'(LETTERS / 2));

    rppg_moddiv #(.DW(CW)) u_mod_first (
        .clk       (clk),
        .ctl       (div_ctl),
        .dividend  (s_axis_tdata[RAND_W-1:0]),
        .divisor   (unpaired),
        .remainder (c1)
    );

    rppg_moddiv #(.DW(CW)) u_mod_second (
        .clk       (clk),
        .ctl       (div_ctl),
        .dividend  (s_axis_tdata[2*RAND_W-1:RAND_W]),
        .divisor   (unpaired - CW'(1)),
        .remainder (c2)
    );

    // next step address
    always_comb
    begin
        pc_next = pc_reg;
        case (uw.cond)
            COND_NEXT:
                pc_next = pc_reg + PC_W'(1);
            COND_JUMP:
                pc_next = uw.target;
            COND_DISPATCH:
                if (in_fire)
                begin
                    if (s_axis_tuser[0] == OP_RESTART)
                        pc_next = PC_RESTART;
                    else if (refuse_now)
                        pc_next = PC_REFUSE;
                    else
                        pc_next = pc_reg + PC_W'(1);
                end
            COND_LOOP_DIV:
                if (div_last)
                    pc_next = pc_reg + PC_W'(1);
            COND_LOOP_SCAN:
                if (scan_last)
                    pc_next = pc_reg + PC_W'(1);
            COND_EMIT:
                if (out_free)
                    pc_next = uw.target;
            default:
                pc_next = PC_WAIT;
        endcase
    end

    // control outputs decoded from the micro-op
    always_comb
    begin
        s_axis_tready = (uw.uop == UOP_WAIT);
        div_ctl.load  = in_fire;
        div_ctl.shift = (uw.uop == UOP_DIV_STEP);
    end

    // datapath next values
    always_comb
    begin
        paired_next      = paired_reg;
        pairs_made_next  = pairs_made_reg;
        pair_target_next = pair_target_reg;
        bit_cnt_next     = bit_cnt_reg;
        j_next           = j_reg;
        rank_next        = rank_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        refused_next     = refused_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (cfg_valid && cfg_ready)
            pair_target_next = cfg_data;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (uw.uop)
            UOP_WAIT:
                if (in_fire)
                begin
                    bit_cnt_next = '0;
                    j_next       = '0;
                    rank_next    = '0;
                    first_next   = '0;
                    second_next  = '0;
                    refused_next = 1'b0;
                end
            UOP_DIV_STEP:
                bit_cnt_next = bit_cnt_reg + BITCNT_W'(1);
            UOP_SCAN_STEP:
            begin
                if (!paired_reg[j_reg])
                begin
                    if (rank_reg == c1)
                        first_next = j_reg;
                    else if (other == c2)
                        second_next = j_reg;
                    rank_next = rank_reg + CW'(1);
                end
                j_next = j_reg + IW'(1);
            end
            UOP_SWAP:
            begin
                paired_next[first_reg]  = 1'b1;
                paired_next[second_reg] = 1'b1;
                pairs_made_next         = pairs_made_reg + PAIR_W'(1);
            end
            UOP_RESTART:
            begin
                paired_next     = '0;
                pairs_made_next = '0;
            end
            UOP_REFUSE:
                refused_next = 1'b1;
            UOP_EMIT:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{OUT_PAD{1'b0}}, board_valid, refused_reg,
                                      run_done, pairs_made_reg,
                                      LETTER_W'(second_reg), LETTER_W'(first_reg)};
                end
            default:
                ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= PC_WAIT;
            paired_reg      <= '0;
            pairs_made_reg  <= '0;
            pair_target_reg <= PAIR_TARGET_RST;
            bit_cnt_reg     <= '0;
            j_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pc_reg          <= pc_next;
            paired_reg      <= paired_next;
            pairs_made_reg  <= pairs_made_next;
            pair_target_reg <= pair_target_next;
            bit_cnt_reg     <= bit_cnt_next;
            j_reg           <= j_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rank_reg     <= rank_next;
        first_reg    <= first_next;
        second_reg   <= second_next;
        refused_reg  <= refused_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // pair count never passes the board limit
    a_pairs_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pairs_made_reg <= PAIR_W'(PAIR_LIMIT))
        else $error("pair count above limit");

    // two paired flags per pair made
    a_paired_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(paired_reg) == 2 * int'(pairs_made_reg))
        else $error("paired flags disagree with pair count");

    // a swap joins two distinct free letters
    a_swap_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.uop == UOP_SWAP) |-> (first_reg != second_reg)
            && !paired_reg[first_reg] && !paired_reg[second_reg])
        else $error("swap of invalid letters");

    // result register is never overwritten while the receiver stalls
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid
            && $stable(m_axis_tdata))
        else $error("pending result lost");
`endif

endmodule

// ===== rtl/rppg_moddiv.sv =====
// Bit-serial restoring remainder unit: one dividend bit per shift step.
// Depends on rppg_pkg (RAND_W, div_ctl_t).
`timescale 1ns / 1ps

module rppg_moddiv
    import rppg_pkg::*;
#(
    parameter int DW = 5
)
(
    input  logic                clk,
    input  div_ctl_t            ctl,
    input  logic [RAND_W-1:0]   dividend,
    input  logic [DW-1:0]       divisor,
    output logic [DW-1:0]       remainder
);

    logic [RAND_W-1:0] dvd_reg;
    logic [RAND_W-1:0] dvd_next;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     rem_next;
    logic [DW:0]       trial;

    // partial remainder stays below divisor, so trial < 2*divisor
    assign trial = {rem_reg, dvd_reg[RAND_W-1]};

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        if (ctl.load)
        begin
            dvd_next = dividend;
            rem_next = '0;
        end
        else if (ctl.shift)
        begin
            dvd_next = {dvd_reg[RAND_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_next = DW'(trial - {1'b0, divisor});
            else
                rem_next = trial[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;

endmodule
